### rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared types, codes and sizes for the stack calculator and its units.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);

	// Quotient magnitude of (a * 2^16) / b spans 48 bits.
	localparam int DIV_STEPS = 48;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		REQ_PUSH = 3'd0,
		REQ_ADD  = 3'd1,
		REQ_SUB  = 3'd2,
		REQ_MUL  = 3'd3,
		REQ_DIV  = 3'd4
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_DIVZERO   = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Stack movement applied at commit.
	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_PUSH,
		ACT_POP2,
		ACT_REPLACE
	} act_t;

	// Per-cell source select.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PREV,
		CELL_NEXT1,
		CELL_NEXT2
	} cell_mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] operand_value;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic signed [31:0]   top_value;
		logic                 top_valid;
		logic [DEPTH_W-1:0]   stack_depth;
	} rsp_t;

endpackage

### rtl/rpn_cell.sv
// ----------------------------------------------------------------------------
// RPN stack cell
// One stack entry; loads from its upper neighbor, its lower neighbors or holds.
// ----------------------------------------------------------------------------
module rpn_cell import rpn_pkg::*; (
	input  logic               clk,
	input  cell_mode_t         mode,
	input  logic signed [31:0] prev,
	input  logic signed [31:0] next1,
	input  logic signed [31:0] next2,
	output logic signed [31:0] val
);

	logic signed [31:0] val_q;

	always_ff @(posedge clk) begin
		case (mode)
			CELL_PREV:  val_q <= prev;
			CELL_NEXT1: val_q <= next1;
			CELL_NEXT2: val_q <= next2;
			default:    val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

### rtl/rpn_div.sv
// ----------------------------------------------------------------------------
// RPN divider
// Radix-2 restoring divider for (a * 2^16) / b, truncated, saturated to 32 bits.
// ----------------------------------------------------------------------------
module rpn_div import rpn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] dividend,
	input  logic signed [31:0] divisor,
	output logic               done,
	output logic signed [31:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          rem_q;
	logic [31:0]          den_q;
	logic [47:0]          num_q;

	logic [31:0] abs_a;
	logic [31:0] abs_b;
	logic [32:0] trial;
	logic        qbit;
	logic [31:0] rem_nx;
	logic        pos_fit;
	logic        neg_fit;

	assign abs_a = dividend[31] ? 32'(-dividend) : 32'(dividend);
	assign abs_b = divisor[31] ? 32'(-divisor) : 32'(divisor);

	// Remainder stays below the divisor, so one bit of headroom is enough.
	assign trial  = {rem_q, num_q[47]} - {1'b0, den_q};
	assign qbit   = ~trial[32];
	assign rem_nx = qbit ? trial[31:0] : {rem_q[30:0], num_q[47]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q  <= dividend[31] ^ divisor[31];
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {abs_a, 16'h0000};
			den_q <= abs_b;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[46:0], qbit};
			rem_q <= rem_nx;
		end
	end

	// Saturate the magnitude per sign of the quotient.
	assign pos_fit = (num_q[47:31] == '0);
	assign neg_fit = (num_q[47:32] == '0) && (!num_q[31] || (num_q[30:0] == '0));

	always_comb begin
		if (neg_q) begin
			quotient = neg_fit ? 32'(-num_q[31:0]) : Q_MIN;
		end else begin
			quotient = pos_fit ? num_q[31:0] : Q_MAX;
		end
	end

	assign done = done_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a finished run");
`endif

endmodule

### rtl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// RPN stack calculator
// Reverse Polish calculator on signed Q16.16 values held in a chain of cells.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload | carries
//  --------+-----------+-----------+---------+--------------------------------
//  request | req_valid | req_stall | req     | push value or arithmetic op
//  result  | rsp_valid | rsp_stall | rsp     | status, top, top_valid, depth
//
//  From accept to commit, push, add, subtract and unknown codes pass the EXEC
//  and DONE states, multiply also MUL, and divide waits in DIV on the 48-step
//  radix-2 divider. A request can be accepted in the cycle after commit; one
//  item is in work at a time.
//  Reset clears the control state and the depth; stack cells are not cleared,
//  and only cells below the depth are ever read.
//  A held result does not block the next accept; a commit waits until the
//  result register is free.
//
// The stack is a row of cells with the top in cell 0. A push shifts every
// cell down by one, an operation replaces the two top entries by its result
// (cell 0 loads the result, the rest shift up by one), and a divide by zero
// drops both operands (everything shifts up by two).
// ----------------------------------------------------------------------------
module rpn_stack_calculator import rpn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	state_t             state_q, state_d;
	req_t               req_q;
	status_t            status_q, status_d;
	act_t               act_q, act_d;
	logic signed [31:0] res_q, res_d;
	logic [DEPTH_W-1:0] dep_q, dep_new;
	logic signed [63:0] prod_q;
	rsp_t               rsp_q, rsp_d;
	logic               rsp_valid_q;

	logic               ld_prod;
	logic               div_start;
	logic               div_done;
	logic signed [31:0] div_quo;
	logic               commit;

	logic signed [31:0] cell_val [STACK_DEPTH];
	cell_mode_t         mode_top, mode_rest;
	logic signed [31:0] top_in;
	logic signed [31:0] top_new;

	logic signed [31:0] lhs, rhs;
	logic signed [32:0] add_w, sub_w;
	logic signed [31:0] add_sat, sub_sat;
	logic signed [63:0] mul_t;
	logic signed [47:0] mul_sh;
	logic signed [31:0] mul_sat;
	logic               few_ops;
	logic               full;

	// ------------------------------------------------------------------
	// Stack cells
	// ------------------------------------------------------------------
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic signed [31:0] prev_w, next1_w, next2_w;
		if (i == 0) begin : g_head
			assign prev_w = top_in;
		end else begin : g_body
			assign prev_w = cell_val[i-1];
		end
		if (i + 1 < STACK_DEPTH) begin : g_n1
			assign next1_w = cell_val[i+1];
		end else begin : g_n1_end
			assign next1_w = '0;
		end
		if (i + 2 < STACK_DEPTH) begin : g_n2
			assign next2_w = cell_val[i+2];
		end else begin : g_n2_end
			assign next2_w = '0;
		end
		rpn_cell u_cell (
			.clk   (clk),
			.mode  ((i == 0) ? mode_top : mode_rest),
			.prev  (prev_w),
			.next1 (next1_w),
			.next2 (next2_w),
			.val   (cell_val[i])
		);
	end

	// ------------------------------------------------------------------
	// Arithmetic on the two top entries (top is the right operand)
	// ------------------------------------------------------------------
	assign rhs = cell_val[0];
	assign lhs = cell_val[1];

	assign add_w   = 33'(lhs) + 33'(rhs);
	assign sub_w   = 33'(lhs) - 33'(rhs);
	assign add_sat = (add_w[32] != add_w[31]) ? (add_w[32] ? Q_MIN : Q_MAX) : add_w[31:0];
	assign sub_sat = (sub_w[32] != sub_w[31]) ? (sub_w[32] ? Q_MIN : Q_MAX) : sub_w[31:0];

	// Round half up, then drop 16 fraction bits (floor) and saturate.
	assign mul_t   = prod_q + 64'sd32768;
	assign mul_sh  = mul_t[63:16];
	assign mul_sat = ((mul_sh[47:31] == '0) || (mul_sh[47:31] == '1)) ? mul_sh[31:0]
		: (mul_sh[47] ? Q_MIN : Q_MAX);

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lhs),
		.divisor  (rhs),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign few_ops = (dep_q < DEPTH_W'(2));
	assign full    = (dep_q == DEPTH_W'(STACK_DEPTH));

	// ------------------------------------------------------------------
	// Control
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		status_d  = status_q;
		act_d     = act_q;
		res_d     = res_q;
		ld_prod   = 1'b0;
		div_start = 1'b0;
		commit    = 1'b0;
		req_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				status_d = ST_OK;
				act_d    = ACT_HOLD;
				state_d  = S_DONE;
				case (req_q.req_type) inside
					REQ_PUSH: begin
						if (full) begin
							status_d = ST_FULL;
						end else begin
							act_d = ACT_PUSH;
						end
					end
					REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
						if (few_ops) begin
							status_d = ST_UNDERFLOW;
						end else if (req_q.req_type == REQ_ADD) begin
							act_d = ACT_REPLACE;
							res_d = add_sat;
						end else if (req_q.req_type == REQ_SUB) begin
							act_d = ACT_REPLACE;
							res_d = sub_sat;
						end else if (req_q.req_type == REQ_MUL) begin
							act_d   = ACT_REPLACE;
							ld_prod = 1'b1;
							state_d = S_MUL;
						end else if (rhs == '0) begin
							status_d = ST_DIVZERO;
							act_d    = ACT_POP2;
						end else begin
							act_d     = ACT_REPLACE;
							div_start = 1'b1;
							state_d   = S_DIV;
						end
					end
					default: begin
						// Unknown codes leave the stack as it is.
					end
				endcase
			end
			S_MUL: begin
				res_d   = mul_sat;
				state_d = S_DONE;
			end
			S_DIV: begin
				if (div_done) begin
					res_d   = div_quo;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Commit: move the cells, update the depth, build the result item
	// ------------------------------------------------------------------
	always_comb begin
		mode_top  = CELL_HOLD;
		mode_rest = CELL_HOLD;
		top_in    = res_q;
		dep_new   = dep_q;
		top_new   = cell_val[0];
		case (act_q)
			ACT_PUSH: begin
				mode_top  = CELL_PREV;
				mode_rest = CELL_PREV;
				top_in    = req_q.operand_value;
				dep_new   = dep_q + 1'b1;
				top_new   = req_q.operand_value;
			end
			ACT_REPLACE: begin
				mode_top  = CELL_PREV;
				mode_rest = CELL_NEXT1;
				dep_new   = dep_q - 1'b1;
				top_new   = res_q;
			end
			ACT_POP2: begin
				mode_top  = CELL_NEXT2;
				mode_rest = CELL_NEXT2;
				dep_new   = dep_q - DEPTH_W'(2);
				top_new   = cell_val[2];
			end
			default: begin
			end
		endcase
		if (!commit) begin
			mode_top  = CELL_HOLD;
			mode_rest = CELL_HOLD;
		end
		rsp_d.status      = status_q;
		rsp_d.top_valid   = (dep_new != '0);
		rsp_d.top_value   = (dep_new != '0) ? top_new : '0;
		rsp_d.stack_depth = dep_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dep_q       <= '0;
			rsp_valid_q <= 1'b0;
			act_q       <= ACT_HOLD;
		end else begin
			act_q <= act_d;
			if (commit) begin
				dep_q       <= dep_new;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold the request, status, result, product and the result item.
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_q <= req;
		end
		status_q <= status_d;
		res_q    <= res_d;
		if (ld_prod) begin
			prod_q <= 64'(lhs) * 64'(rhs);
		end
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		dep_q <= DEPTH_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");
	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.top_valid == (rsp.stack_depth != '0)))
		else $error("top_valid disagrees with depth");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside a divide");
	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid && rsp.stack_depth == $past(dep_new))
		else $error("commit did not present its result");
`endif

endmodule
